FILE: hw/rtl/upr_pkg.sv
// ----------------------------------------------------------------------------
// upr_pkg
// Shared types, constants and CRC byte functions of the update packet receiver.
// ----------------------------------------------------------------------------
package upr_pkg;

    localparam int MAX_PAYLOAD = 256;

    localparam logic [7:0] SYNC_A     = 8'hB1;
    localparam logic [7:0] SYNC_B     = 8'h0A;
    localparam logic [7:0] KIND_START = 8'd1;
    localparam logic [7:0] KIND_DATA  = 8'd2;
    localparam logic [7:0] KIND_END   = 8'd3;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_SYNC = 2'd1;
    localparam logic [1:0] PH_HEAD = 2'd2;
    localparam logic [1:0] PH_BODY = 2'd3;

    localparam logic [3:0] RSN_OK        = 4'd0;
    localparam logic [3:0] RSN_TIMEOUT   = 4'd1;
    localparam logic [3:0] RSN_TOO_LONG  = 4'd2;
    localparam logic [3:0] RSN_CRC16     = 4'd3;
    localparam logic [3:0] RSN_START_LEN = 4'd4;
    localparam logic [3:0] RSN_ZERO_SIZE = 4'd5;
    localparam logic [3:0] RSN_NO_SESS   = 4'd6;
    localparam logic [3:0] RSN_SEQ       = 4'd7;
    localparam logic [3:0] RSN_OVERFLOW  = 4'd8;
    localparam logic [3:0] RSN_SHORT     = 4'd9;
    localparam logic [3:0] RSN_IMAGE_CRC = 4'd10;
    localparam logic [3:0] RSN_TYPE      = 4'd11;
    localparam logic [3:0] RSN_TOO_LARGE = 4'd12;

    localparam logic [0:0] OP_BYTE = 1'b0;
    localparam logic [0:0] OP_TICK = 1'b1;

    localparam logic [0:0] REG_CAPACITY = 1'b0;
    localparam logic [0:0] REG_TIMEOUT  = 1'b1;

    localparam logic [24:0] CAPACITY_RESET = 25'd1015808;
    localparam logic [31:0] TIMEOUT_RESET  = 32'd5000;

    typedef struct packed {
        logic [0:0] op;
        logic [7:0] byte_in;
    } in_word_t;

    typedef struct packed {
        logic        ack;
        logic [3:0]  reason;
        logic        launch;
        logic [24:0] bytes_done;
        logic [7:0]  next_seq;
    } out_word_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'h0};
        for (int i = 0; i < 8; i++)
        begin
            c = c[31] ? ({c[30:0], 1'b0} ^ 32'h04C11DB7) : {c[30:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/upr_in_if.sv
// ----------------------------------------------------------------------------
// upr_in_if
// Input channel: valid, ready and one input word.
// ----------------------------------------------------------------------------
interface upr_in_if;
    logic              valid;
    logic              ready;
    upr_pkg::in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/upr_out_if.sv
// ----------------------------------------------------------------------------
// upr_out_if
// Output channel: valid, ready and one result word.
// ----------------------------------------------------------------------------
interface upr_out_if;
    logic               valid;
    logic               ready;
    upr_pkg::out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/upr_cfg.sv
// ----------------------------------------------------------------------------
// upr_cfg
// APB register file holding the capacity and timeout registers.
// ----------------------------------------------------------------------------
module upr_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [24:0] app_capacity,
    output logic [31:0] timeout_ticks
);
    logic [24:0] cap_reg;
    logic [31:0] tmo_reg;
    logic        wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign app_capacity = cap_reg;
    assign timeout_ticks = tmo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= upr_pkg::CAPACITY_RESET;
            tmo_reg <= upr_pkg::TIMEOUT_RESET;
        end
        else if (wr && paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == upr_pkg::REG_CAPACITY)
                cap_reg <= pwdata[24:0];
            else
                tmo_reg <= pwdata;
        end
    end

    always_comb
    begin
        case (paddr[2])
            upr_pkg::REG_CAPACITY: prdata = {7'd0, cap_reg};
            default:               prdata = tmo_reg;
        endcase
    end
endmodule

FILE: hw/rtl/upr_core.sv
// ----------------------------------------------------------------------------
// upr_core
// Deframer, packet checker and session state; one word a cycle.
// ----------------------------------------------------------------------------
module upr_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  upr_pkg::in_word_t  in_data,
    input  logic [24:0]        app_capacity,
    input  logic [31:0]        timeout_ticks,
    output logic               res_valid,
    output upr_pkg::out_word_t res_data,
    output logic               finished
);
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [7:0]  type_reg, type_next, seq_reg, seq_next;
    logic [15:0] len_reg, len_next, chk_reg, chk_next, crc16_reg, crc16_next;
    logic [63:0] sw_reg, sw_next;
    logic [31:0] size_reg, size_next, icrc_reg, icrc_next;
    logic [31:0] pend_reg, pend_next, comm_reg, comm_next;
    logic [24:0] wc_reg, wc_next;
    logic [7:0]  eseq_reg, eseq_next;
    logic [31:0] idle_reg, idle_next, idle_inc;
    logic        fin_reg, fin_next;
    logic        emit, ok, go, fin_pkt;
    logic [3:0]  why;
    logic [7:0]  b;
    logic [15:0] crc_f, cnt_inc;
    logic [63:0] sw_f;
    logic [26:0] sum;

    assign b = in_data.byte_in;
    assign finished = fin_reg;
    assign idle_inc = (idle_reg == 32'hFFFFFFFF) ? idle_reg : idle_reg + 32'd1;
    assign cnt_inc = cnt_reg + 16'd1;

    always_comb
    begin
        phase_next = phase_reg; cnt_next = cnt_reg; type_next = type_reg;
        seq_next = seq_reg; len_next = len_reg; chk_next = chk_reg;
        crc16_next = crc16_reg; sw_next = sw_reg; size_next = size_reg;
        icrc_next = icrc_reg; pend_next = pend_reg; comm_next = comm_reg;
        wc_next = wc_reg; eseq_next = eseq_reg; idle_next = idle_reg;
        fin_next = fin_reg;
        emit = 1'b0; ok = 1'b0; why = upr_pkg::RSN_OK; go = 1'b0;
        fin_pkt = 1'b0;
        crc_f = crc16_reg; sw_f = sw_reg;
        sum = {2'b0, wc_reg} + {11'b0, len_reg};
        if (in_valid && !fin_reg)
        begin
            if (in_data.op == upr_pkg::OP_TICK)
            begin
                idle_next = idle_inc;
                if (idle_inc >= timeout_ticks)
                begin
                    idle_next = '0; phase_next = upr_pkg::PH_HUNT; cnt_next = '0;
                    emit = 1'b1; why = upr_pkg::RSN_TIMEOUT;
                end
            end
            else
            begin
                idle_next = '0;
                case (phase_reg)
                    upr_pkg::PH_HUNT:
                    begin
                        if (b == upr_pkg::SYNC_A)
                            phase_next = upr_pkg::PH_SYNC;
                    end
                    upr_pkg::PH_SYNC:
                    begin
                        if (b == upr_pkg::SYNC_B)
                        begin
                            phase_next = upr_pkg::PH_HEAD; cnt_next = '0;
                            crc16_next = 16'hFFFF;
                        end
                        else
                            phase_next = upr_pkg::PH_HUNT;
                    end
                    upr_pkg::PH_HEAD:
                    begin
                        if (cnt_reg < 16'd4)
                            crc16_next = upr_pkg::crc16_byte(crc16_reg, b);
                        case (cnt_reg[2:0])
                            3'd0: type_next = b;
                            3'd1: seq_next = b;
                            3'd2: len_next = {8'd0, b};
                            3'd3: len_next = {b, len_reg[7:0]};
                            3'd4: chk_next = {8'd0, b};
                            default: chk_next = {b, chk_reg[7:0]};
                        endcase
                        if (cnt_reg < 16'd5)
                            cnt_next = cnt_inc;
                        else
                        begin
                            cnt_next = '0;
                            if (len_reg > 16'(upr_pkg::MAX_PAYLOAD))
                            begin
                                phase_next = upr_pkg::PH_HUNT;
                                emit = 1'b1; why = upr_pkg::RSN_TOO_LONG;
                            end
                            else
                            begin
                                pend_next = comm_reg; sw_next = '0; sw_f = '0;
                                crc_f = crc16_reg;
                                if (len_reg == 16'd0)
                                    fin_pkt = 1'b1;
                                else
                                    phase_next = upr_pkg::PH_BODY;
                            end
                        end
                    end
                    default:
                    begin
                        crc_f = upr_pkg::crc16_byte(crc16_reg, b);
                        crc16_next = crc_f;
                        pend_next = upr_pkg::crc32_byte(pend_reg, b);
                        if (cnt_reg < 16'd8)
                            sw_f[8*cnt_reg[2:0] +: 8] = b;
                        sw_next = sw_f;
                        cnt_next = cnt_inc;
                        if (cnt_inc >= len_reg)
                            fin_pkt = 1'b1;
                    end
                endcase
                if (fin_pkt)
                begin
                    phase_next = upr_pkg::PH_HUNT; cnt_next = '0; emit = 1'b1;
                    if (crc_f != chk_next)
                        why = upr_pkg::RSN_CRC16;
                    else if (type_reg == upr_pkg::KIND_START)
                    begin
                        if (len_reg != 16'd8)
                            why = upr_pkg::RSN_START_LEN;
                        else
                        begin
                            icrc_next = sw_f[63:32];
                            if (sw_f[31:0] == 32'd0)
                            begin
                                size_next = '0; why = upr_pkg::RSN_ZERO_SIZE;
                            end
                            else if (sw_f[31:0] > {7'd0, app_capacity})
                            begin
                                size_next = '0; why = upr_pkg::RSN_TOO_LARGE;
                            end
                            else
                            begin
                                size_next = sw_f[31:0]; wc_next = '0; eseq_next = '0;
                                comm_next = 32'hFFFFFFFF; ok = 1'b1;
                            end
                        end
                    end
                    else if (type_reg == upr_pkg::KIND_DATA)
                    begin
                        if (size_reg == 32'd0)
                            why = upr_pkg::RSN_NO_SESS;
                        else if (seq_reg != eseq_reg)
                            why = upr_pkg::RSN_SEQ;
                        else if ({5'd0, sum} > size_reg)
                            why = upr_pkg::RSN_OVERFLOW;
                        else
                        begin
                            wc_next = sum[24:0]; eseq_next = eseq_reg + 8'd1;
                            comm_next = pend_next; ok = 1'b1;
                        end
                    end
                    else if (type_reg == upr_pkg::KIND_END)
                    begin
                        if (size_reg == 32'd0)
                            why = upr_pkg::RSN_NO_SESS;
                        else if ({7'd0, wc_reg} != size_reg)
                            why = upr_pkg::RSN_SHORT;
                        else if (comm_reg != icrc_reg)
                            why = upr_pkg::RSN_IMAGE_CRC;
                        else
                        begin
                            fin_next = 1'b1; ok = 1'b1; go = 1'b1;
                        end
                    end
                    else
                        why = upr_pkg::RSN_TYPE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= upr_pkg::PH_HUNT; cnt_reg <= '0; type_reg <= '0;
            seq_reg <= '0; len_reg <= '0; chk_reg <= '0; crc16_reg <= 16'hFFFF;
            sw_reg <= '0; size_reg <= '0; icrc_reg <= '0;
            pend_reg <= 32'hFFFFFFFF; comm_reg <= 32'hFFFFFFFF;
            wc_reg <= '0; eseq_reg <= '0; idle_reg <= '0; fin_reg <= 1'b0;
            res_valid <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next; cnt_reg <= cnt_next; type_reg <= type_next;
            seq_reg <= seq_next; len_reg <= len_next; chk_reg <= chk_next;
            crc16_reg <= crc16_next; sw_reg <= sw_next; size_reg <= size_next;
            icrc_reg <= icrc_next; pend_reg <= pend_next; comm_reg <= comm_next;
            wc_reg <= wc_next; eseq_reg <= eseq_next; idle_reg <= idle_next;
            fin_reg <= fin_next;
            res_valid <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_data.ack <= ok;
            res_data.reason <= why;
            res_data.launch <= go;
            res_data.bytes_done <= wc_next;
            res_data.next_seq <= eseq_next;
        end
    end
endmodule

FILE: hw/rtl/upr_outq.sv
// ----------------------------------------------------------------------------
// upr_outq
// Two-entry result queue that decouples the core from output stalls.
// ----------------------------------------------------------------------------
module upr_outq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  upr_pkg::out_word_t push_data,
    output logic               room,
    upr_out_if.source          out
);
    upr_pkg::out_word_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       pop;

    assign pop = out.valid && out.ready;
    assign out.valid = cnt_reg != 2'd0;
    assign out.data = mem_reg[rp_reg];
    // Room for one more word even if a result is in flight in the core: the
    // count after this cycle's push and pop must leave one entry free.
    assign room = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && (!push || pop)) ||
                  (cnt_reg == 2'd2 && pop && !push);

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

FILE: hw/rtl/update_packet_receiver.sv
// ----------------------------------------------------------------------------
// update_packet_receiver
// Firmware update packet deframer with CRC16 and image CRC32 checks.
// ----------------------------------------------------------------------------
// Each input word is a link byte or an idle tick; a word can be offered every
// cycle while input ready is high. The whole header/payload step, both CRC
// byte updates and the packet verdict sit between the core state registers and
// a result register; the result of the word that finishes a packet or times
// out goes from that register into a two-entry queue, which holds results while
// the output is stalled; input ready drops only when that queue could fill.
// After an accepted END the block raises launch and ignores every further word
// until reset. Registers: app_capacity at byte 0, timeout_ticks at byte 4.
module update_packet_receiver (
    input  logic        clk,
    input  logic        rst_n,
    upr_in_if.sink      in,
    upr_out_if.source   out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [24:0]        app_capacity;
    logic [31:0]        timeout_ticks;
    logic               res_valid, room, finished;
    upr_pkg::out_word_t res_data;

    upr_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .app_capacity(app_capacity), .timeout_ticks(timeout_ticks)
    );

    // Accept only when the queue can absorb the result in flight plus this one.
    assign in.ready = room;

    upr_core u_core (
        .clk(clk), .rst_n(rst_n), .in_valid(in.valid && in.ready),
        .in_data(in.data), .app_capacity(app_capacity),
        .timeout_ticks(timeout_ticks), .res_valid(res_valid),
        .res_data(res_data), .finished(finished)
    );

    upr_outq u_outq (
        .clk(clk), .rst_n(rst_n), .push(res_valid), .push_data(res_data),
        .room(room), .out(out)
    );

`ifndef SYNTH
    // A launch result is always an ACK.
    assert property (@(posedge clk) disable iff (!rst_n)
        out.valid |-> (!out.data.launch || out.data.ack))
        else $error("launch without ack");
    // An ACK always carries reason ok.
    assert property (@(posedge clk) disable iff (!rst_n)
        out.valid && out.data.ack |-> out.data.reason == upr_pkg::RSN_OK)
        else $error("ack with nonzero reason");
    // Once finished, the core produces no further result.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(finished) && finished |=> !res_valid)
        else $error("result after launch");
`endif
endmodule

FILE: dv/upr_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upr_tb_pkg
// Bit-serial CRC helpers shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package upr_tb_pkg;

    // CRC16-CCITT, one byte, MSB first, non-reflected.
    function automatic logic [15:0] ccitt_next(input logic [15:0] c, input logic [7:0] b);
        for (int k = 7; k >= 0; k--)
        begin
            c = {c[14:0], 1'b0} ^ ((c[15] ^ b[k]) ? 16'h1021 : 16'h0000);
        end
        return c;
    endfunction

    // CRC32-MPEG2, one byte, MSB first, non-reflected, no final inversion.
    function automatic logic [31:0] mpeg2_next(input logic [31:0] c, input logic [7:0] b);
        for (int k = 7; k >= 0; k--)
        begin
            c = {c[30:0], 1'b0} ^ ((c[31] ^ b[k]) ? 32'h04C11DB7 : 32'h0);
        end
        return c;
    endfunction

endpackage

FILE: dv/upr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upr_checker
// Watches the link, result and register ports, tracks the deframer state and
// compares every result word with the predicted one.
// ----------------------------------------------------------------------------
module upr_checker
    import upr_pkg::*;
    import upr_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    upr_in_if           in_mon,
    upr_out_if          out_mon,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          errors,
    output int          outstanding
);

    logic [24:0] capacity;
    logic [31:0] tick_limit;
    logic [1:0]  phase;
    logic [15:0] fcount;
    logic [7:0]  ptype;
    logic [7:0]  pseq;
    logic [15:0] plen;
    logic [15:0] pcheck;
    logic [15:0] hdr_crc;
    logic [63:0] start_bytes;
    logic [31:0] img_size;
    logic [31:0] img_crc;
    logic [31:0] crc_pending;
    logic [31:0] crc_committed;
    logic [24:0] written;
    logic [7:0]  seq_expect;
    logic [31:0] idle_count;
    logic        launched;

    out_word_t verdicts[$];

    assign outstanding = verdicts.size();

    task automatic post(input logic ok, input logic [3:0] why, input logic go);
        out_word_t w;
        w.ack        = ok;
        w.reason     = why;
        w.launch     = go;
        w.bytes_done = written;
        w.next_seq   = seq_expect;
        verdicts.push_back(w);
    endtask

    // Packet verdict once the header and all payload bytes are in.
    task automatic close_packet();
        logic [31:0] size;
        phase  = PH_HUNT;
        fcount = '0;
        if (hdr_crc != pcheck)
            post(1'b0, RSN_CRC16, 1'b0);
        else if (ptype == KIND_START)
        begin
            if (plen != 16'd8)
                post(1'b0, RSN_START_LEN, 1'b0);
            else
            begin
                size    = start_bytes[31:0];
                img_crc = start_bytes[63:32];
                if (size == 0)
                begin
                    img_size = '0;
                    post(1'b0, RSN_ZERO_SIZE, 1'b0);
                end
                else if (size > {7'd0, capacity})
                begin
                    img_size = '0;
                    post(1'b0, RSN_TOO_LARGE, 1'b0);
                end
                else
                begin
                    img_size      = size;
                    written       = '0;
                    seq_expect    = '0;
                    crc_committed = 32'hFFFF_FFFF;
                    post(1'b1, RSN_OK, 1'b0);
                end
            end
        end
        else if (ptype == KIND_DATA)
        begin
            if (img_size == 0)
                post(1'b0, RSN_NO_SESS, 1'b0);
            else if (pseq != seq_expect)
                post(1'b0, RSN_SEQ, 1'b0);
            else if ({8'd0, written} + {17'd0, plen} > {1'b0, img_size})
                post(1'b0, RSN_OVERFLOW, 1'b0);
            else
            begin
                written       = written + {9'd0, plen};
                seq_expect    = seq_expect + 8'd1;
                crc_committed = crc_pending;
                post(1'b1, RSN_OK, 1'b0);
            end
        end
        else if (ptype == KIND_END)
        begin
            if (img_size == 0)
                post(1'b0, RSN_NO_SESS, 1'b0);
            else if ({7'd0, written} != img_size)
                post(1'b0, RSN_SHORT, 1'b0);
            else if (crc_committed != img_crc)
                post(1'b0, RSN_IMAGE_CRC, 1'b0);
            else
            begin
                launched = 1'b1;
                post(1'b1, RSN_OK, 1'b1);
            end
        end
        else
            post(1'b0, RSN_TYPE, 1'b0);
    endtask

    task automatic absorb_word(input in_word_t w);
        logic [7:0] b;
        b = w.byte_in;
        if (launched)
            return;
        if (w.op == OP_TICK)
        begin
            if (idle_count != 32'hFFFF_FFFF)
                idle_count = idle_count + 32'd1;
            if (idle_count >= tick_limit)
            begin
                idle_count = '0;
                phase      = PH_HUNT;
                fcount     = '0;
                post(1'b0, RSN_TIMEOUT, 1'b0);
            end
            return;
        end
        idle_count = '0;
        case (phase)
            PH_HUNT:
                if (b == SYNC_A)
                    phase = PH_SYNC;
            PH_SYNC:
                if (b == SYNC_B)
                begin
                    phase   = PH_HEAD;
                    fcount  = '0;
                    hdr_crc = 16'hFFFF;
                end
                else
                    phase = PH_HUNT;
            PH_HEAD:
            begin
                case (fcount)
                    16'd0: ptype = b;
                    16'd1: pseq = b;
                    16'd2: plen = {8'd0, b};
                    16'd3: plen[15:8] = b;
                    16'd4: pcheck = {8'd0, b};
                    default: pcheck[15:8] = b;
                endcase
                if (fcount < 4)
                    hdr_crc = ccitt_next(hdr_crc, b);
                if (fcount < 5)
                    fcount = fcount + 16'd1;
                else
                begin
                    fcount = '0;
                    if (plen > MAX_PAYLOAD)
                    begin
                        phase = PH_HUNT;
                        post(1'b0, RSN_TOO_LONG, 1'b0);
                    end
                    else
                    begin
                        crc_pending = crc_committed;
                        start_bytes = '0;
                        if (plen == 0)
                            close_packet();
                        else
                            phase = PH_BODY;
                    end
                end
            end
            default:
            begin
                hdr_crc     = ccitt_next(hdr_crc, b);
                crc_pending = mpeg2_next(crc_pending, b);
                if (fcount < 8)
                    start_bytes[8*fcount +: 8] = b;
                fcount = fcount + 16'd1;
                if (fcount >= plen)
                    close_packet();
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        out_word_t got;
        if (!rst_n)
        begin
            capacity      = CAPACITY_RESET;
            tick_limit    = TIMEOUT_RESET;
            phase         = PH_HUNT;
            fcount        = '0;
            ptype         = '0;
            pseq          = '0;
            plen          = '0;
            pcheck        = '0;
            hdr_crc       = 16'hFFFF;
            start_bytes   = '0;
            img_size      = '0;
            img_crc       = '0;
            crc_pending   = 32'hFFFF_FFFF;
            crc_committed = 32'hFFFF_FFFF;
            written       = '0;
            seq_expect    = '0;
            idle_count    = '0;
            launched      = 1'b0;
            errors        = 0;
            verdicts.delete();
        end
        else
        begin
            // Register writes only happen while no word is in flight.
            if (psel && penable && pwrite)
            begin
                if (paddr[2] == REG_CAPACITY)
                    capacity = pwdata[24:0];
                else
                    tick_limit = pwdata;
            end
            if (out_mon.valid && out_mon.ready)
            begin
                got = out_mon.data;
                if (verdicts.size() == 0)
                begin
                    $display("%0t: unexpected result word %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = verdicts.pop_front();
                    if (got.ack !== want.ack)
                    begin
                        $display("%0t: ack expected %h got %h", $time, want.ack, got.ack);
                        errors++;
                    end
                    if (got.reason !== want.reason)
                    begin
                        $display("%0t: reason expected %0d got %0d", $time,
                                 want.reason, got.reason);
                        errors++;
                    end
                    if (got.launch !== want.launch)
                    begin
                        $display("%0t: launch expected %h got %h", $time,
                                 want.launch, got.launch);
                        errors++;
                    end
                    if (got.bytes_done !== want.bytes_done)
                    begin
                        $display("%0t: bytes_done expected %0d got %0d", $time,
                                 want.bytes_done, got.bytes_done);
                        errors++;
                    end
                    if (got.next_seq !== want.next_seq)
                    begin
                        $display("%0t: next_seq expected %0d got %0d", $time,
                                 want.next_seq, got.next_seq);
                        errors++;
                    end
                end
            end
            if (in_mon.valid && in_mon.ready)
                absorb_word(in_mon.data);
        end
    end

endmodule

FILE: dv/update_packet_receiver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// update_packet_receiver_test
// Drives framed update packets, noise and idle ticks into the deframer under
// several register settings, with random bursts and output stalls, and takes
// the verdict from the checker that predicts every result word.
// ----------------------------------------------------------------------------
module update_packet_receiver_test;
    import upr_pkg::*;
    import upr_tb_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          outstanding;

    upr_in_if  in_ch ();
    upr_out_if out_ch ();

    update_packet_receiver DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .in      (in_ch),
        .out     (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    upr_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_mon      (in_ch),
        .out_mon     (out_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // Words waiting to go out on the link, in order.
    in_word_t link_q[$];
    int       phase_words;

    // Current register values, so the stimulus can aim at the edges.
    logic [31:0] cur_capacity;
    logic [31:0] cur_timeout;

    // Image session as the stimulus believes the block sees it.
    bit          sess_open;
    logic [7:0]  image[$];
    int          sess_done;
    logic [7:0]  sess_seq;
    bit          claim_good;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The watchdog ends the run when nothing moves for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
                quiet = 0;
            else
                quiet++;
            if (quiet >= 20000)
            begin
                $display("FAIL update_packet_receiver");
                $finish;
            end
        end
    end

    // Link sender: bursts of random length with random gaps. A word once offered
    // stays on the bus until it is taken.
    initial
    begin
        int  burst;
        int  gap;
        bit  took;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        burst = 0;
        gap   = 0;
        forever
        begin
            @(posedge clk);
            took = in_ch.valid && in_ch.ready;
            @(negedge clk);
            if (!(in_ch.valid && !took))
            begin
                if (took)
                begin
                    void'(link_q.pop_front());
                    if (burst > 0)
                        burst--;
                    if (burst == 0 && $urandom_range(0, 2) != 0)
                        gap = $urandom_range(1, 7);
                end
                if (gap > 0)
                begin
                    gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (link_q.size() != 0 && rst_n)
                begin
                    if (burst == 0)
                        burst = $urandom_range(1, 48);
                    in_ch.valid <= 1'b1;
                    in_ch.data  <= link_q[0];
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver: stall modes are chosen at random, from
    // always ready down to rarely ready.
    initial
    begin
        int mode;
        int left;
        int tick;
        out_ch.ready = 1'b0;
        left = 0;
        tick = 0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 300);
            end
            left--;
            tick++;
            case (mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= $urandom_range(0, 1);
                2: out_ch.ready <= ($urandom_range(0, 7) == 0);
                default: out_ch.ready <= ((tick % 16) < 11);
            endcase
        end
    end

    task automatic push_word(input logic [0:0] op, input logic [7:0] b);
        in_word_t w;
        w.op      = op;
        w.byte_in = b;
        link_q.push_back(w);
        phase_words++;
    endtask

    // Frame a packet; a header with a length above the payload limit is sent
    // without its payload since the block drops back to hunting right away.
    task automatic send_packet(input logic [7:0] kind, input logic [7:0] seq,
                               input logic [15:0] len, input logic [7:0] body[$],
                               input bit spoil);
        logic [15:0] c;
        c = 16'hFFFF;
        c = ccitt_next(c, kind);
        c = ccitt_next(c, seq);
        c = ccitt_next(c, len[7:0]);
        c = ccitt_next(c, len[15:8]);
        foreach (body[i])
            c = ccitt_next(c, body[i]);
        if (spoil)
            c = c ^ (16'h1 << $urandom_range(0, 15));
        push_word(OP_BYTE, SYNC_A);
        push_word(OP_BYTE, SYNC_B);
        push_word(OP_BYTE, kind);
        push_word(OP_BYTE, seq);
        push_word(OP_BYTE, len[7:0]);
        push_word(OP_BYTE, len[15:8]);
        push_word(OP_BYTE, c[7:0]);
        push_word(OP_BYTE, c[15:8]);
        if (len <= MAX_PAYLOAD)
            foreach (body[i])
                push_word(OP_BYTE, body[i]);
    endtask

    task automatic send_start(input logic [31:0] size, input logic [31:0] crc,
                              input logic [15:0] len, input bit spoil);
        logic [7:0] body[$];
        logic [63:0] words;
        words = {crc, size};
        for (int i = 0; i < len; i++)
            body.push_back(i < 8 ? words[8*i +: 8] : 8'($urandom));
        send_packet(KIND_START, 8'($urandom), len, body, spoil);
    endtask

    // If the timeout is 32 or less, ticks up to it bring the block back to hunting from any phase.
    task automatic flush_ticks();
        if (cur_timeout <= 32)
            for (int i = 0; i < cur_timeout; i++)
                push_word(OP_TICK, 8'($urandom));
    endtask

    // Opens an image session, mostly with a valid START. The claimed image CRC
    // is sometimes wrong so that END can be rejected on the image check.
    task automatic open_session();
        int          pick;
        logic [31:0] size;
        logic [31:0] crc;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            size = 0;
        else if (pick < 9)
            size = (pick == 5) ? 32'hFFFF_FFFF : cur_capacity + 1;
        else if (cur_capacity < 300 || pick == 9)
            size = $urandom_range(1, cur_capacity < 300 ? cur_capacity : 300);
        else
            size = $urandom_range(1, 300);
        image.delete();
        crc = 32'hFFFF_FFFF;
        if (size >= 1 && size <= cur_capacity && size <= 300)
            for (int i = 0; i < size; i++)
            begin
                image.push_back(8'($urandom));
                crc = mpeg2_next(crc, image[i]);
            end
        claim_good = ($urandom_range(0, 9) != 0);
        if (!claim_good)
            crc = crc ^ 32'h0000_0100;
        if (pick >= 95)
            send_start(size, crc, 16'($urandom_range(0, 20)), 1'b0);
        else if (pick >= 92)
            send_start(size, crc, 16'd8, 1'b1);
        else
        begin
            send_start(size, crc, 16'd8, 1'b0);
            if (size >= 1 && size <= cur_capacity && size <= 300)
            begin
                sess_open = 1'b1;
                sess_done = 0;
                sess_seq  = 8'd0;
            end
        end
    endtask

    task automatic session_step();
        int         pick;
        int         len;
        logic [7:0] body[$];
        logic [7:0] none[$];
        if (!sess_open)
        begin
            open_session();
            return;
        end
        if (sess_done == image.size())
        begin
            // Never a full valid END before the end of the run: it would launch.
            if (!claim_good)
                send_packet(KIND_END, 8'($urandom), 16'd0, none, 1'b0);
            else
                send_packet(KIND_END, 8'($urandom), 16'd0, none, 1'b1);
            sess_open = 1'b0;
            return;
        end
        pick = $urandom_range(0, 99);
        len  = $urandom_range(1, 40);
        if (len > image.size() - sess_done)
            len = image.size() - sess_done;
        if (pick < 4)
            len = 0;
        else if (pick < 9)
            len = image.size() - sess_done + $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
            body.push_back(sess_done + i < image.size() ? image[sess_done + i] : 8'($urandom));
        if (pick >= 5 && pick < 9)
            send_packet(KIND_DATA, sess_seq, 16'(len), body, 1'b0);
        else if (pick < 16)
            send_packet(KIND_DATA, sess_seq + 8'($urandom_range(1, 255)), 16'(len), body, 1'b0);
        else if (pick < 21)
            send_packet(KIND_DATA, sess_seq, 16'(len), body, 1'b1);
        else if (pick < 25)
            send_packet(KIND_END, 8'($urandom), 16'($urandom_range(0, 3)), none, 1'b0);
        else if (pick < 28)
            send_packet(8'($urandom_range(4, 255)), sess_seq, 16'(len), body, 1'b0);
        else
        begin
            send_packet(KIND_DATA, sess_seq, 16'(len), body, 1'b0);
            sess_done += len;
            sess_seq  += 8'd1;
        end
    endtask

    // Noise: stray bytes and ticks, cut-off packets and oversized headers.
    task automatic noise_step();
        int         pick;
        logic [7:0] none[$];
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            repeat ($urandom_range(1, 6))
                push_word(($urandom_range(0, 4) == 0) ? OP_TICK : OP_BYTE, 8'($urandom));
            flush_ticks();
        end
        else if (pick < 60)
            send_packet(8'($urandom), 8'($urandom), 16'($urandom_range(MAX_PAYLOAD + 1, 65535)),
                        none, 1'b0);
        else if (pick < 80 && cur_timeout <= 32)
        begin
            push_word(OP_BYTE, SYNC_A);
            push_word(OP_BYTE, SYNC_B);
            repeat ($urandom_range(0, 12))
                push_word(OP_BYTE, 8'($urandom));
            flush_ticks();
        end
        else
            flush_ticks();
    endtask

    task automatic reg_write(input logic [0:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_CAPACITY)
            cur_capacity = value;
        else
            cur_timeout = value;
    endtask

    // Waits until every word has been taken and every result has come back,
    // then lets the result path settle.
    task automatic drain();
        while (link_q.size() != 0 || in_ch.valid || outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] caps[5];
        logic [31:0] touts[5];
        logic [7:0]  none[$];
        logic [7:0]  body[$];
        logic [31:0] crc;

        caps  = '{32'd1015808, 32'd1, 32'd16777216, 32'd200, 32'd5000};
        touts = '{32'd12, 32'd1, 32'hFFFF_FFFF, 32'd3, 32'd16};

        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        cur_capacity = CAPACITY_RESET;
        cur_timeout  = TIMEOUT_RESET;
        sess_open    = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: a doubled first magic byte is not a new start, an oversized
        // header, an unknown type, and END with no session open.
        push_word(OP_BYTE, SYNC_A);
        push_word(OP_BYTE, SYNC_A);
        push_word(OP_BYTE, SYNC_B);
        push_word(OP_TICK, 8'hFF);
        send_packet(8'hFF, 8'hFF, 16'hFFFF, none, 1'b0);
        send_packet(8'h00, 8'h00, 16'd0, none, 1'b0);
        send_packet(KIND_END, 8'h00, 16'd0, none, 1'b0);
        drain();

        // Random phases, one per register setting, extremes included.
        for (int p = 0; p < 5; p++)
        begin
            reg_write(REG_CAPACITY, caps[p]);
            reg_write(REG_TIMEOUT, touts[p]);
            sess_open   = 1'b0;
            phase_words = 0;
            flush_ticks();
            while (phase_words < 300)
            begin
                if ($urandom_range(0, 99) < 75)
                    session_step();
                else
                    noise_step();
            end
            drain();
        end

        // Closing session with a valid END, which launches; words after it are
        // ignored.
        flush_ticks();
        crc = 32'hFFFF_FFFF;
        for (int i = 0; i < 20; i++)
        begin
            body.push_back(8'($urandom));
            crc = mpeg2_next(crc, body[i]);
        end
        send_start(32'd20, crc, 16'd8, 1'b0);
        send_packet(KIND_DATA, 8'd0, 16'd20, body, 1'b0);
        send_packet(KIND_END, 8'd0, 16'd0, none, 1'b0);
        repeat (10)
            push_word(OP_TICK, 8'h00);
        send_packet(KIND_END, 8'd0, 16'd0, none, 1'b0);
        drain();

        if (errors == 0)
            $display("PASS update_packet_receiver");
        else
            $display("FAIL update_packet_receiver");
        $finish;
    end

endmodule
